FILE: src/hrtfnd_pkg.sv
// Shared types and constants for the nearest-direction response table.
// Field widths, status and operation codes, and the request/result structs.
// No dependencies.
package hrtfnd_pkg;

    localparam int unsigned EL_W      = 14;     // elevation, signed, 1/64 degree
    localparam int unsigned AZ_W      = 15;     // wrapped azimuth, 1/64 degree
    localparam int unsigned RATE_W    = 19;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned ID_W      = 16;     // response handle field on the ports
    localparam int unsigned FULL_TURN = 23040;  // 360 degrees

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic              op;
        logic [AZ_W-1:0]   az;      // already wrapped
        logic [EL_W-1:0]   el;
        logic [CHAN_W-1:0] chans;
        logic [RATE_W-1:0] rate;
    } req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [EL_W-1:0] el;
        logic [AZ_W-1:0] az;
        logic            left_found;
        logic            right_found;
        logic            empty;
    } res_t;

endpackage

FILE: src/hrtfnd_engine.sv
// Slot memory and scan sequencer of the nearest-direction response table.
// One synchronous memory holds {valid, elevation, azimuth, handle} per slot.
// Depends on hrtfnd_pkg.
module hrtfnd_engine #(
    parameter int TABLE_DEPTH = 256,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  hrtfnd_pkg::req_t       req,
    input  logic [HANDLE_BITS-1:0] req_handle,
    output logic                   idle,
    input  logic                   out_free,
    output logic                   res_valid,
    output hrtfnd_pkg::res_t       res,
    output logic [HANDLE_BITS-1:0] res_left,
    output logic [HANDLE_BITS-1:0] res_right
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = hrtfnd_pkg::EL_W;
    localparam int ZW = hrtfnd_pkg::AZ_W;
    localparam int BW = EW + 1;
    localparam int WW = 1 + EW + ZW + HANDLE_BITS;
    localparam logic [AW-1:0] LAST    = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_INS    = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_ELEV   = 3'd4;
    localparam logic [2:0] S_AZIM   = 3'd5;
    localparam logic [2:0] S_MIRROR = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [WW-1:0] slot_mem [TABLE_DEPTH];
    logic [WW-1:0] rd_q_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] wr_data;

    logic [2:0]             state_reg, state_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic                   issuing_reg, issuing_next;
    logic                   pv_reg, pv_next;
    logic [AW-1:0]          pidx_reg, pidx_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [hrtfnd_pkg::RATE_W-1:0] rate_reg, rate_next;
    hrtfnd_pkg::req_t       req_reg, req_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic                   have_reg, have_next;
    logic [EW:0]            best_reg, best_next;
    logic [EW-1:0]          oel_reg, oel_next;
    logic [ZW-1:0]          oaz_reg, oaz_next;
    logic [1:0]             status_reg, status_next;
    logic                   lfound_reg, lfound_next;
    logic                   rfound_reg, rfound_next;
    logic [HANDLE_BITS-1:0] lresp_reg, lresp_next;
    logic [HANDLE_BITS-1:0] rresp_reg, rresp_next;
    logic                   match_found_reg, match_found_next;
    logic [AW-1:0]          match_idx_reg, match_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [AW-1:0]          free_idx_reg, free_idx_next;

    // read-back slot fields
    logic                   q_valid;
    logic [EW-1:0]          q_el;
    logic [ZW-1:0]          q_az;
    logic [HANDLE_BITS-1:0] q_handle;
    logic [EW:0]            el_sub, el_dist;
    logic [ZW-1:0]          az_dist, mirror_az;
    logic [EW:0]            az_dist_w;
    logic                   el_lower, scan_end, ins_ok;

    assign q_valid  = rd_q_reg[WW-1];
    assign q_el     = rd_q_reg[WW-2 -: EW];
    assign q_az     = rd_q_reg[HANDLE_BITS+ZW-1 -: ZW];
    assign q_handle = rd_q_reg[HANDLE_BITS-1:0];

    assign el_sub   = {q_el[EW-1], q_el} - {req_reg.el[EW-1], req_reg.el};
    assign el_dist  = el_sub[EW] ? (~el_sub + 1'b1) : el_sub;
    assign el_lower = $signed(q_el) < $signed(oel_reg);
    assign az_dist  = (q_az > req_reg.az) ? (q_az - req_reg.az) : (req_reg.az - q_az);
    // azimuth distance never exceeds one turn, so it fits the distance register
    assign az_dist_w = BW'(az_dist);
    assign mirror_az = (oaz_reg == '0) ? '0 : (ZW'(hrtfnd_pkg::FULL_TURN) - oaz_reg);
    assign scan_end = pv_reg && (pidx_reg == LAST);
    assign ins_ok   = (req.chans == hrtfnd_pkg::CHAN_W'(1)) &&
                      ((rate_reg == '0) || (req.rate == rate_reg));

    // simple dual-port style memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= slot_mem[addr_reg];
    end

    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        issuing_next     = issuing_reg;
        pv_next          = issuing_reg;
        pidx_next        = addr_reg;
        count_next       = count_reg;
        rate_next        = rate_reg;
        req_next         = req_reg;
        handle_next      = handle_reg;
        have_next        = have_reg;
        best_next        = best_reg;
        oel_next         = oel_reg;
        oaz_next         = oaz_reg;
        status_next      = status_reg;
        lfound_next      = lfound_reg;
        rfound_next      = rfound_reg;
        lresp_next       = lresp_reg;
        rresp_next       = rresp_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        wr_en            = 1'b0;
        wr_addr          = addr_reg;
        wr_data          = '0;

        // read address sweep, one slot a cycle
        if (issuing_reg)
        begin
            if (addr_reg == LAST)
            begin
                addr_next    = '0;
                issuing_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + 1'b1;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_reg;
                if (addr_reg == LAST)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = req;
                    handle_next = req_handle;
                    oel_next    = req.el;
                    oaz_next    = req.az;
                    status_next = hrtfnd_pkg::ST_OK;
                    lfound_next = 1'b0;
                    rfound_next = 1'b0;
                    lresp_next  = '0;
                    rresp_next  = '0;
                    have_next   = 1'b0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    if (req.op == hrtfnd_pkg::OP_INSERT)
                    begin
                        if (!ins_ok)
                        begin
                            status_next = hrtfnd_pkg::ST_REJECT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            addr_next    = '0;
                            issuing_next = 1'b1;
                            state_next   = S_INS;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = hrtfnd_pkg::ST_EMPTY;
                        oel_next    = '0;
                        oaz_next    = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        addr_next    = '0;
                        issuing_next = 1'b1;
                        state_next   = S_ELEV;
                    end
                end
            end
            S_INS:
            begin
                if (pv_reg)
                begin
                    if (q_valid && (q_el == req_reg.el) && (q_az == req_reg.az))
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = pidx_reg;
                    end
                    if (!q_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pidx_reg;
                    end
                end
                if (scan_end)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                wr_data    = {1'b1, req_reg.el, req_reg.az, handle_reg};
                state_next = S_DONE;
                if (match_found_reg)
                begin
                    wr_en     = 1'b1;
                    wr_addr   = match_idx_reg;
                    rate_next = req_reg.rate;
                end
                else if ((count_reg < DEPTH_C) && free_found_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = free_idx_reg;
                    rate_next  = req_reg.rate;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    status_next = hrtfnd_pkg::ST_FULL;
                end
            end
            S_ELEV:
            begin
                if (pv_reg && q_valid &&
                    (!have_reg || (el_dist < best_reg) ||
                     ((el_dist == best_reg) && el_lower)))
                begin
                    have_next = 1'b1;
                    best_next = el_dist;
                    oel_next  = q_el;
                end
                if (scan_end)
                begin
                    have_next    = 1'b0;
                    addr_next    = '0;
                    issuing_next = 1'b1;
                    state_next   = S_AZIM;
                end
            end
            S_AZIM:
            begin
                if (pv_reg && q_valid && (q_el == oel_reg) &&
                    (!have_reg || (az_dist_w < best_reg) ||
                     ((az_dist_w == best_reg) && (q_az < oaz_reg))))
                begin
                    have_next   = 1'b1;
                    best_next   = az_dist_w;
                    oaz_next    = q_az;
                    rresp_next  = q_handle;
                    rfound_next = 1'b1;
                end
                if (scan_end)
                begin
                    addr_next    = '0;
                    issuing_next = 1'b1;
                    state_next   = S_MIRROR;
                end
            end
            S_MIRROR:
            begin
                if (pv_reg && q_valid && (q_el == oel_reg) && (q_az == mirror_az))
                begin
                    lfound_next = 1'b1;
                    lresp_next  = q_handle;
                end
                if (scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            addr_reg    <= '0;
            issuing_reg <= 1'b0;
            pv_reg      <= 1'b0;
            count_reg   <= '0;
            rate_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            issuing_reg <= issuing_next;
            pv_reg      <= pv_next;
            count_reg   <= count_next;
            rate_reg    <= rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg        <= pidx_next;
        req_reg         <= req_next;
        handle_reg      <= handle_next;
        have_reg        <= have_next;
        best_reg        <= best_next;
        oel_reg         <= oel_next;
        oaz_reg         <= oaz_next;
        status_reg      <= status_next;
        lfound_reg      <= lfound_next;
        rfound_reg      <= rfound_next;
        lresp_reg       <= lresp_next;
        rresp_reg       <= rresp_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE) && out_free;

    assign res.status      = status_reg;
    assign res.el          = oel_reg;
    assign res.az          = oaz_reg;
    assign res.left_found  = lfound_reg;
    assign res.right_found = rfound_reg;
    assign res.empty       = (count_reg == '0);
    assign res_left        = lresp_reg;
    assign res_right       = rresp_reg;

endmodule

FILE: src/hrtf_nearest_direction_table.sv
// Top level of the nearest-direction response table: stream ports, azimuth
// wrap and the output register. Depends on hrtfnd_pkg and hrtfnd_engine.
//
// Stores up to TABLE_DEPTH response handles keyed by (elevation, azimuth) in
// 1/64 degree; azimuth is wrapped into 0..23039 on entry. s_tuser selects the
// operation: insert (mono only, sample rate must match the first accepted
// nonzero rate; an existing key is overwritten, a new key on a full table
// returns status 2) or lookup (snap to nearest stored elevation, then nearest
// azimuth in that ring, ties to the lower key; left handle comes from the
// mirrored azimuth 360 - az and is flagged missing if absent). One result
// transaction per input transaction. Timing is set by the single slot memory,
// which is swept one slot per cycle: an insert makes one sweep for key match
// and free slot, then a write; a lookup makes an elevation sweep, an azimuth
// sweep and a mirror sweep; a rejected insert or a lookup on an empty table
// makes no sweep. One item is processed at a time; the next one is accepted as
// soon as the previous result is in the output register. After reset the
// memory is cleared slot by slot, during which s_tready stays low.
module hrtf_nearest_direction_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int HANDLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] azimuth, [29:16] elevation, [45:30] response_id,
    // [53:46] channel_count, [72:54] sample_rate, [79:73] zero
    input  logic [79:0] s_tdata,
    // [0] operation
    input  logic        s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [15:2] snapped_elevation, [30:16] snapped_azimuth,
    // [46:31] left_response, [47] left_found, [63:48] right_response,
    // [64] right_found, [65] table_empty, [71:66] zero
    output logic [71:0] m_tdata
);

    localparam int IW = hrtfnd_pkg::ID_W;

    logic                   start;
    logic                   idle;
    logic                   out_free;
    logic                   res_valid;
    hrtfnd_pkg::req_t       req;
    hrtfnd_pkg::res_t       res;
    logic [HANDLE_BITS-1:0] req_handle;
    logic [HANDLE_BITS-1:0] res_left;
    logic [HANDLE_BITS-1:0] res_right;
    logic [HANDLE_BITS+IW-1:0] handle_in_ext;
    logic [HANDLE_BITS+IW-1:0] left_ext;
    logic [HANDLE_BITS+IW-1:0] right_ext;

    // azimuth wrap: bias by two turns so the value is positive, then two
    // conditional subtracts bring it into one turn
    logic [16:0] az_t0, az_t1, az_t2;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [71:0] m_tdata_reg, m_tdata_next;

    assign az_t0 = 17'({{2{s_tdata[15]}}, s_tdata[15:0]} +
                       18'(2 * hrtfnd_pkg::FULL_TURN));
    assign az_t1 = (az_t0 >= 17'(2 * hrtfnd_pkg::FULL_TURN)) ?
                   (az_t0 - 17'(2 * hrtfnd_pkg::FULL_TURN)) : az_t0;
    assign az_t2 = (az_t1 >= 17'(hrtfnd_pkg::FULL_TURN)) ?
                   (az_t1 - 17'(hrtfnd_pkg::FULL_TURN)) : az_t1;

    // keep the low HANDLE_BITS of the id, zero-extended if wider
    assign handle_in_ext = {{HANDLE_BITS{1'b0}}, s_tdata[45:30]};
    assign req_handle    = handle_in_ext[HANDLE_BITS-1:0];

    assign req.op    = s_tuser;
    assign req.az    = az_t2[hrtfnd_pkg::AZ_W-1:0];
    assign req.el    = s_tdata[29:16];
    assign req.chans = s_tdata[53:46];
    assign req.rate  = s_tdata[72:54];

    assign s_tready = idle;
    assign start    = s_tvalid && idle;
    assign out_free = !m_tvalid_reg || m_tready;

    hrtfnd_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .req_handle (req_handle),
        .idle       (idle),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .res_left   (res_left),
        .res_right  (res_right)
    );

    assign left_ext  = {{IW{1'b0}}, res_left};
    assign right_ext = {{IW{1'b0}}, res_right};

    // output register: holds a finished result while the engine takes the
    // next transaction
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0,
                             res.empty,
                             res.right_found,
                             right_ext[IW-1:0],
                             res.left_found,
                             left_ext[IW-1:0],
                             res.az,
                             res.el,
                             res.status};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: bench/hrtf_table_checker.sv
`timescale 1ns / 100ps
// Result checker for the nearest-direction response table: watches both stream channels,
// predicts each result from its own copy of the table and compares field by field.
// Depends on hrtfnd_pkg.
module hrtf_table_checker #(
    parameter int TABLE_DEPTH = 256,
    parameter int HANDLE_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [79:0]       s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [71:0]       m_tdata,
    output int unsigned       mismatches,
    output int unsigned       outstanding
);

    localparam int TURN = int'(hrtfnd_pkg::FULL_TURN);
    localparam int EW   = hrtfnd_pkg::EL_W;
    localparam int ZW   = hrtfnd_pkg::AZ_W;
    localparam int IW   = hrtfnd_pkg::ID_W;
    localparam int RW   = hrtfnd_pkg::RATE_W;
    localparam int CW   = hrtfnd_pkg::CHAN_W;

    // m_tdata[65:0], highest field first
    typedef struct packed {
        logic              table_empty;
        logic              right_found;
        logic [IW-1:0]     right_response;
        logic              left_found;
        logic [IW-1:0]     left_response;
        logic [ZW-1:0]     azimuth;
        logic [EW-1:0]     elevation;
        logic [1:0]        status;
    } direction_result_t;

    bit                slot_used   [TABLE_DEPTH];
    int                slot_elev   [TABLE_DEPTH];
    int                slot_azim   [TABLE_DEPTH];
    logic [IW-1:0]     slot_handle [TABLE_DEPTH];
    logic [RW-1:0]     fixed_rate = '0;
    int unsigned       used_count = 0;

    direction_result_t expected_directions[$];

    function automatic int find_direction(int el, int az);
        int i;
        int hit;
        hit = -1;
        for (i = 0; i < TABLE_DEPTH; i++)
            if (hit < 0 && slot_used[i] && slot_elev[i] == el && slot_azim[i] == az)
                hit = i;
        return hit;
    endfunction

    // Applies one request to the table copy and returns the result it produces.
    function automatic direction_result_t predict_direction(logic op, logic [79:0] word);
        direction_result_t r;
        int                az;
        int                el;
        int                slot;
        int                i;
        int                d;
        int                best;
        int                bel;
        int                baz;
        int                rs;
        int                ls;
        bit                have;
        logic [IW-1:0]     handle;
        logic [CW-1:0]     chans;
        logic [RW-1:0]     rate;

        r      = '0;
        az     = int'($signed(word[15:0])) % TURN;
        if (az < 0)
            az += TURN;
        el     = int'($signed(word[29:16]));
        handle = word[45:30] & IW'((64'd1 << HANDLE_BITS) - 64'd1);
        chans  = word[53:46];
        rate   = word[72:54];

        if (op == hrtfnd_pkg::OP_INSERT)
        begin
            r.elevation = EW'(el);
            r.azimuth   = ZW'(az);
            if (chans != 8'd1 || (fixed_rate != '0 && rate != fixed_rate))
            begin
                r.status = hrtfnd_pkg::ST_REJECT;
            end
            else
            begin
                slot = find_direction(el, az);
                if (slot < 0 && used_count < TABLE_DEPTH)
                begin
                    for (i = 0; i < TABLE_DEPTH && slot < 0; i++)
                        if (!slot_used[i])
                            slot = i;
                    if (slot >= 0)
                    begin
                        slot_used[slot] = 1'b1;
                        slot_elev[slot] = el;
                        slot_azim[slot] = az;
                        used_count++;
                    end
                end
                if (slot < 0)
                begin
                    r.status = hrtfnd_pkg::ST_FULL;
                end
                else
                begin
                    slot_handle[slot] = handle;
                    fixed_rate        = rate;
                end
            end
        end
        else if (used_count == 0)
        begin
            r.status = hrtfnd_pkg::ST_EMPTY;
        end
        else
        begin
            // elevation ring first, then azimuth inside it; ties go low
            have = 1'b0;
            best = 0;
            bel  = 0;
            baz  = 0;
            rs   = -1;
            for (i = 0; i < TABLE_DEPTH; i++)
            begin
                if (slot_used[i])
                begin
                    d = (el > slot_elev[i]) ? el - slot_elev[i] : slot_elev[i] - el;
                    if (!have || d < best || (d == best && slot_elev[i] < bel))
                    begin
                        have = 1'b1;
                        best = d;
                        bel  = slot_elev[i];
                    end
                end
            end
            have = 1'b0;
            for (i = 0; i < TABLE_DEPTH; i++)
            begin
                if (slot_used[i] && slot_elev[i] == bel)
                begin
                    d = (az > slot_azim[i]) ? az - slot_azim[i] : slot_azim[i] - az;
                    if (!have || d < best || (d == best && slot_azim[i] < baz))
                    begin
                        have = 1'b1;
                        best = d;
                        baz  = slot_azim[i];
                        rs   = i;
                    end
                end
            end
            r.elevation = EW'(bel);
            r.azimuth   = ZW'(baz);
            if (rs >= 0)
            begin
                r.right_response = slot_handle[rs];
                r.right_found    = 1'b1;
            end
            ls = find_direction(bel, (baz == 0) ? 0 : TURN - baz);
            if (ls >= 0)
            begin
                r.left_response = slot_handle[ls];
                r.left_found    = 1'b1;
            end
        end
        r.table_empty = (used_count == 0);
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        direction_result_t seen;
        direction_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_directions.push_back(predict_direction(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                seen = m_tdata[65:0];
                if (expected_directions.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: %h", $realtime, m_tdata);
                end
                else
                begin
                    want = expected_directions.pop_front();
                    if (seen.status !== want.status || seen.elevation !== want.elevation
                        || seen.azimuth !== want.azimuth
                        || seen.left_response !== want.left_response
                        || seen.left_found !== want.left_found
                        || seen.right_response !== want.right_response
                        || seen.right_found !== want.right_found
                        || seen.table_empty !== want.table_empty)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: want st=%0d el=%0d az=%0d L=%h/%0b R=%h/%0b mt=%0b",
                                     $realtime, want.status, $signed(want.elevation),
                                     want.azimuth, want.left_response, want.left_found,
                                     want.right_response, want.right_found, want.table_empty);
                            $display("%0t:  got st=%0d el=%0d az=%0d L=%h/%0b R=%h/%0b mt=%0b",
                                     $realtime, seen.status, $signed(seen.elevation),
                                     seen.azimuth, seen.left_response, seen.left_found,
                                     seen.right_response, seen.right_found, seen.table_empty);
                        end
                    end
                end
            end
            outstanding <= expected_directions.size();
        end
    end

endmodule

FILE: bench/tb_hrtf_nearest_direction_table.sv
`timescale 1ns / 100ps
// Testbench top for hrtf_nearest_direction_table: clock, reset, request stimulus and verdict.
// Depends on hrtfnd_pkg, hrtf_table_checker and the block itself.
module tb_hrtf_nearest_direction_table;

    localparam int                 RW          = hrtfnd_pkg::RATE_W;
    // Sized for the slowest legal run, about 1170 items each as long as a full
    // lookup plus idle gaps, with the limit well above that run.
    localparam int unsigned        CYCLE_LIMIT = 4_000_000;
    localparam int unsigned        SETTLE      = 3 * 256 + 32;
    localparam logic [RW-1:0]      BASE_RATE   = 19'd48000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;   // set during stretches where neither side idles

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    hrtf_nearest_direction_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hrtf_table_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // One request transaction. The idle gap is drawn per item; valid is only
    // lowered when a gap is actually taken, so back-to-back items never see a
    // low and a high assignment in the same step.
    task automatic send_item(input logic op, input logic [15:0] az, input logic [13:0] el,
                             input logic [15:0] id, input logic [7:0] chans,
                             input logic [RW-1:0] rate);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        // azimuth, elevation, response_id, channel_count, sample_rate from bit 0 up
        s_tdata  <= {7'd0, rate, chans, id, el, az};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Lookup with junk in the fields the block ignores for this operation.
    task automatic look_up(input logic [15:0] az, input logic [13:0] el);
        send_item(hrtfnd_pkg::OP_LOOKUP, az, el, 16'($urandom), 8'($urandom),
                  RW'($urandom));
    endtask

    // Lands on a grid point, exactly between two (tie), or near one.
    function automatic logic [15:0] near_offset();
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'd720;
            2: return 16'(-720);
            default: return 16'(int'($urandom_range(0, 2880)) - 1440);
        endcase
    endfunction

    // Random mix: mostly lookups and well-formed inserts on a coarse grid
    // (9 elevation rings x 16 azimuths, symmetric so mirrors usually exist),
    // plus off-grid keys and malformed inserts.
    task automatic send_random_item();
        int unsigned pick;
        logic [15:0] az;
        logic [13:0] el;
        logic [7:0]  chans;
        if ($urandom_range(0, 49) == 0)
            no_idle = !no_idle;
        pick = $urandom_range(0, 99);
        el   = 14'((int'($urandom_range(0, 8)) - 4) * 1440);
        az   = 16'(int'($urandom_range(0, 15)) * 1440);
        if (pick < 45)
            look_up(az + near_offset(), el + 14'(near_offset()));
        else if (pick < 55)
            look_up(16'($urandom), 14'($urandom));
        else if (pick < 85)
            send_item(hrtfnd_pkg::OP_INSERT, az, el, 16'($urandom), 8'd1, BASE_RATE);
        else if (pick < 90)
            send_item(hrtfnd_pkg::OP_INSERT, 16'($urandom), 14'($urandom), 16'($urandom),
                      8'd1, BASE_RATE);
        else if (pick < 95)
        begin
            // any channel count but mono
            chans = 8'($urandom_range(0, 254));
            if (chans != 8'd0)
                chans = chans + 8'd1;
            send_item(hrtfnd_pkg::OP_INSERT, az, el, 16'($urandom), chans, RW'($urandom));
        end
        else
            send_item(hrtfnd_pkg::OP_INSERT, az, el, 16'($urandom), 8'd1, RW'($urandom));
    endtask

    task automatic wait_for_results();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Result side: per result, either accept at once or hold tready low until
    // tvalid shows up and for a hold drawn per result after that.
    initial
    begin : result_sink
        int unsigned hold;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 5);
            if (hold != 0)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
                while (!m_tvalid) @(posedge clk);
                repeat (hold - 1) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int i;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= hrtfnd_pkg::OP_INSERT;
        s_tdata  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // lookup before anything is stored: table empty
        look_up(16'd0, 14'd0);
        // non-mono responses are rejected
        send_item(hrtfnd_pkg::OP_INSERT, 16'd0, 14'd0, 16'h0001, 8'd2, BASE_RATE);
        send_item(hrtfnd_pkg::OP_INSERT, 16'd0, 14'd0, 16'h0001, 8'd0, BASE_RATE);
        // first accepted insert with a zero rate leaves the rate unfixed
        send_item(hrtfnd_pkg::OP_INSERT, 16'd0, 14'd0, 16'hFFFF, 8'd1, 19'd0);
        // so a nonzero rate is still taken, and from now on fixed
        send_item(hrtfnd_pkg::OP_INSERT, 16'd5760, 14'd0, 16'h1234, 8'd1, BASE_RATE);
        // rate mismatch, zero rate after fixing, all-ones fields
        send_item(hrtfnd_pkg::OP_INSERT, 16'd100, 14'd0, 16'h0002, 8'd1, 19'd44100);
        send_item(hrtfnd_pkg::OP_INSERT, 16'd100, 14'd0, 16'h0002, 8'd1, 19'd0);
        send_item(hrtfnd_pkg::OP_INSERT, 16'hFFFF, 14'h3FFF, 16'hFFFF, 8'hFF, 19'h7FFFF);
        // negative azimuth wraps to 270 degrees: mirror of 90
        send_item(hrtfnd_pkg::OP_INSERT, 16'(-5760), 14'd0, 16'hABCD, 8'd1, BASE_RATE);
        // same key again overwrites the handle
        send_item(hrtfnd_pkg::OP_INSERT, 16'd5760, 14'd0, 16'h5555, 8'd1, BASE_RATE);
        look_up(16'd5000, 14'd0);
        // ring extremes, azimuth just below a full turn either way
        send_item(hrtfnd_pkg::OP_INSERT, 16'd23039, 14'd5760, 16'h0001, 8'd1, BASE_RATE);
        send_item(hrtfnd_pkg::OP_INSERT, 16'(-23039), 14'(-5760), 16'h0002, 8'd1, BASE_RATE);
        // elevation ties in both directions go to the lower ring
        look_up(16'd0, 14'd2880);
        look_up(16'd0, 14'(-2880));
        // extreme field values: wrap of the most positive and negative azimuth
        look_up(16'h7FFF, 14'h1FFF);
        look_up(16'h8000, 14'h2000);
        send_item(hrtfnd_pkg::OP_INSERT, 16'd11520, 14'd0, 16'h0007, 8'd1, BASE_RATE);
        // azimuth tie between 0 and 90 degrees
        look_up(16'd2880, 14'd0);
        // no wrap in the azimuth search: 359.98 degrees snaps to 270
        look_up(16'd23039, 14'd0);
        send_item(hrtfnd_pkg::OP_INSERT, 16'h7FFF, 14'h1FFF, 16'h00F0, 8'd1, BASE_RATE);
        send_item(hrtfnd_pkg::OP_INSERT, 16'h8000, 14'h2000, 16'h0F00, 8'd1, BASE_RATE);
        look_up(16'd0, 14'd8000);
        send_item(hrtfnd_pkg::OP_INSERT, 16'hFFFF, 14'd0, 16'h0000, 8'd1, BASE_RATE);
        // azimuth 0 mirrors onto itself
        look_up(16'd1, 14'd0);

        // ---- random, table filling up ----
        for (i = 0; i < 420; i++)
            send_random_item();

        // hold off until every result is back, then keep going
        s_tvalid <= 1'b0;
        wait_for_results();

        // push past the table depth with keys on an otherwise unused ring;
        // the tail of these gets the table-full status
        for (i = 0; i < 300; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                no_idle = !no_idle;
            send_item(hrtfnd_pkg::OP_INSERT, 16'(i * 64), 14'd8100, 16'($urandom), 8'd1,
                      BASE_RATE);
        end

        // ---- random, table full: overwrites pass, new keys bounce ----
        for (i = 0; i < 426; i++)
            send_random_item();

        s_tvalid <= 1'b0;
        wait_for_results();
        // let any stray late result show up
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: hrtf_nearest_direction_table.f
src/hrtfnd_pkg.sv
src/hrtfnd_engine.sv
src/hrtf_nearest_direction_table.sv
bench/hrtf_table_checker.sv
bench/tb_hrtf_nearest_direction_table.sv
